[src/polygon_to_axis_aligned_box_unit_assert.svh]
// ----------------------------------------------------------------------------
// polygon_to_axis_aligned_box_unit assertion macros
// wrappers for the concurrent checks of the box unit, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef POLYGON_TO_AXIS_ALIGNED_BOX_UNIT_ASSERT_SVH
`define POLYGON_TO_AXIS_ALIGNED_BOX_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PTAB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ptab check failed");
`define PTAB_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("ptab check failed after reset");
`else
`define PTAB_ASSERT(lbl, clk, rst, prop)
`define PTAB_ASSERT_NR(lbl, clk, prop)
`endif
`endif

[src/ptab_pkg.sv]
// ----------------------------------------------------------------------------
// ptab_pkg
// shared constants and types of the polygon to axis aligned box unit
// ----------------------------------------------------------------------------
package ptab_pkg;
   localparam int COORD_WIDTH_DEF     = 16;
   localparam int COORD_FRAC_BITS_DEF = 4;
   // scale is unsigned Q2.16
   localparam int S_BITS  = 18;
   localparam int S_FRAC  = 16;
   localparam int Q_BITS  = 2 * S_BITS;
   // first root is taken of d12*d23*2^64
   localparam int RAD_PAD = 64;
   localparam int POS_W   = 14;
   localparam int LEN_W   = 13;

   typedef logic [S_BITS-1:0] scale_type;
   typedef logic [Q_BITS-1:0] quot_type;
endpackage

[src/ptab_front.sv]
// ----------------------------------------------------------------------------
// ptab_front
// extents, centroid sums, squared side lengths, extent area and their product
// ----------------------------------------------------------------------------
module ptab_front #(
   parameter int CW = ptab_pkg::COORD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic signed [CW-1:0]   c0x,
   input  logic signed [CW-1:0]   c0y,
   input  logic signed [CW-1:0]   c1x,
   input  logic signed [CW-1:0]   c1y,
   input  logic signed [CW-1:0]   c2x,
   input  logic signed [CW-1:0]   c2y,
   input  logic signed [CW-1:0]   c3x,
   input  logic signed [CW-1:0]   c3y,
   output logic                   out_valid,
   output logic [4*CW+1:0]        out_prod,
   output logic [CW-1:0]          out_ex,
   output logic [CW-1:0]          out_ey,
   output logic [2*CW-1:0]        out_a2,
   output logic signed [CW+1:0]   out_sx,
   output logic signed [CW+1:0]   out_sy,
   output logic                   out_deg
);
   import ptab_pkg::*;

   localparam int DW = 2 * CW + 1;
   localparam int HW = DW / 2;

   logic signed [CW-1:0] xa, xb, xmin, xmax, ya, yb, ymin, ymax;
   logic signed [CW-1:0] xc, xd, yc, yd;
   logic signed [CW:0]   exd, eyd;

   // stage 1
   logic                 v1_ff;
   logic [CW-1:0]        ex1_ff, ey1_ff;
   logic signed [CW+1:0] sx1_ff, sy1_ff;
   logic signed [CW:0]   dx12_ff, dy12_ff, dx23_ff, dy23_ff;
   // stage 2
   logic                 v2_ff;
   logic [2*CW-1:0]      sqa_ff, sqb_ff, sqc_ff, sqd_ff, a22_ff;
   logic [CW-1:0]        ex2_ff, ey2_ff;
   logic signed [CW+1:0] sx2_ff, sy2_ff;
   logic signed [2*CW+1:0] sqa_in, sqb_in, sqc_in, sqd_in;
   // stage 3
   logic                 v3_ff, deg3_ff;
   logic [DW-1:0]        d12_ff, d23_ff;
   logic [2*CW-1:0]      a23_ff;
   logic [CW-1:0]        ex3_ff, ey3_ff;
   logic signed [CW+1:0] sx3_ff, sy3_ff;
   // stage 4
   logic                 v4_ff, deg4_ff;
   logic [DW+HW-1:0]     pplo_ff;
   logic [2*DW-HW-1:0]   pphi_ff;
   logic [2*CW-1:0]      a24_ff;
   logic [CW-1:0]        ex4_ff, ey4_ff;
   logic signed [CW+1:0] sx4_ff, sy4_ff;
   // stage 5
   logic                 v5_ff, deg5_ff;
   logic [2*DW-1:0]      prod5_ff;
   logic [2*CW-1:0]      a25_ff;
   logic [CW-1:0]        ex5_ff, ey5_ff;
   logic signed [CW+1:0] sx5_ff, sy5_ff;

   always_comb begin
      xa   = (c0x < c1x) ? c0x : c1x;
      xb   = (c2x < c3x) ? c2x : c3x;
      xmin = (xa < xb) ? xa : xb;
      xc   = (c0x > c1x) ? c0x : c1x;
      xd   = (c2x > c3x) ? c2x : c3x;
      xmax = (xc > xd) ? xc : xd;
      ya   = (c0y < c1y) ? c0y : c1y;
      yb   = (c2y < c3y) ? c2y : c3y;
      ymin = (ya < yb) ? ya : yb;
      yc   = (c0y > c1y) ? c0y : c1y;
      yd   = (c2y > c3y) ? c2y : c3y;
      ymax = (yc > yd) ? yc : yd;
      exd  = (CW+1)'(xmax) - (CW+1)'(xmin);
      eyd  = (CW+1)'(ymax) - (CW+1)'(ymin);
   end

   assign sqa_in = dx12_ff * dx12_ff;
   assign sqb_in = dy12_ff * dy12_ff;
   assign sqc_in = dx23_ff * dx23_ff;
   assign sqd_in = dy23_ff * dy23_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (en) begin
         ex1_ff   <= exd[CW-1:0];
         ey1_ff   <= eyd[CW-1:0];
         sx1_ff   <= (CW+2)'(c0x) + (CW+2)'(c1x) + (CW+2)'(c2x) + (CW+2)'(c3x);
         sy1_ff   <= (CW+2)'(c0y) + (CW+2)'(c1y) + (CW+2)'(c2y) + (CW+2)'(c3y);
         dx12_ff  <= (CW+1)'(c1x) - (CW+1)'(c2x);
         dy12_ff  <= (CW+1)'(c1y) - (CW+1)'(c2y);
         dx23_ff  <= (CW+1)'(c2x) - (CW+1)'(c3x);
         dy23_ff  <= (CW+1)'(c2y) - (CW+1)'(c3y);

         sqa_ff   <= sqa_in[2*CW-1:0];
         sqb_ff   <= sqb_in[2*CW-1:0];
         sqc_ff   <= sqc_in[2*CW-1:0];
         sqd_ff   <= sqd_in[2*CW-1:0];
         a22_ff   <= ex1_ff * ey1_ff;
         ex2_ff   <= ex1_ff;
         ey2_ff   <= ey1_ff;
         sx2_ff   <= sx1_ff;
         sy2_ff   <= sy1_ff;

         d12_ff   <= DW'(sqa_ff) + DW'(sqb_ff);
         d23_ff   <= DW'(sqc_ff) + DW'(sqd_ff);
         deg3_ff  <= (a22_ff == '0);
         a23_ff   <= a22_ff;
         ex3_ff   <= ex2_ff;
         ey3_ff   <= ey2_ff;
         sx3_ff   <= sx2_ff;
         sy3_ff   <= sy2_ff;

         // product cut in two halves of d23
         pplo_ff  <= d12_ff * d23_ff[HW-1:0];
         pphi_ff  <= d12_ff * d23_ff[DW-1:HW];
         deg4_ff  <= deg3_ff;
         a24_ff   <= a23_ff;
         ex4_ff   <= ex3_ff;
         ey4_ff   <= ey3_ff;
         sx4_ff   <= sx3_ff;
         sy4_ff   <= sy3_ff;

         prod5_ff <= (2*DW)'(pplo_ff) + ((2*DW)'(pphi_ff) << HW);
         deg5_ff  <= deg4_ff;
         a25_ff   <= a24_ff;
         ex5_ff   <= ex4_ff;
         ey5_ff   <= ey4_ff;
         sx5_ff   <= sx4_ff;
         sy5_ff   <= sy4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign out_prod  = prod5_ff;
   assign out_ex    = ex5_ff;
   assign out_ey    = ey5_ff;
   assign out_a2    = a25_ff;
   assign out_sx    = sx5_ff;
   assign out_sy    = sy5_ff;
   assign out_deg   = deg5_ff;
endmodule

[src/ptab_isqrt.sv]
// ----------------------------------------------------------------------------
// ptab_isqrt
// pipelined integer square root, one root bit per stage, with sideband
// ----------------------------------------------------------------------------
module ptab_isqrt #(
   parameter int RAD_W  = ptab_pkg::Q_BITS,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [RAD_W-1:0]    in_rad,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [RAD_W/2-1:0]  out_root,
   output logic [SIDE_W-1:0]   out_side
);
   import ptab_pkg::*;

   localparam int N  = RAD_W / 2;
   localparam int RW = N + 2;

   logic [RAD_W-1:0]  rad_ff  [N];
   logic [N-1:0]      root_ff [N];
   logic [RW-1:0]     rem_ff  [N];
   logic [SIDE_W-1:0] side_ff [N];
   logic              vld_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [RAD_W-1:0]  rad_prev;
      logic [N-1:0]      root_prev;
      logic [RW-1:0]     rem_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              vld_prev;
      logic [RW-1:0]     rem_cat, trial;
      logic              take;

      if (k == 0) begin : g_first
         assign rad_prev  = in_rad;
         assign root_prev = '0;
         assign rem_prev  = '0;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rad_prev  = rad_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      // remainder never exceeds twice the partial root
      assign rem_cat = {rem_prev[N-1:0], rad_prev[RAD_W-1 -: 2]};
      assign trial   = {root_prev, 2'b01};
      assign take    = (rem_cat >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
         if (en) begin
            rad_ff[k]  <= rad_prev << 2;
            root_ff[k] <= {root_prev[N-2:0], take};
            rem_ff[k]  <= take ? (rem_cat - trial) : rem_cat;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];
endmodule

[src/ptab_div.sv]
// ----------------------------------------------------------------------------
// ptab_div
// pipelined restoring divider, one quotient bit per stage, saturating quotient
// ----------------------------------------------------------------------------
module ptab_div #(
   parameter int NUM_W  = 65,
   parameter int DEN_W  = 32,
   parameter int Q_W    = ptab_pkg::Q_BITS,
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [DEN_W-1:0]   in_den,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output logic [Q_W-1:0]     out_quot,
   output logic [SIDE_W-1:0]  out_side
);
   import ptab_pkg::*;

   localparam int REM_W = DEN_W + 1;
   localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic [CMP_W-1:0]  num_ext, lim_ext;

   logic [REM_W-1:0]  rem_ff  [Q_W+1];
   logic [Q_W-1:0]    low_ff  [Q_W+1];
   logic [Q_W-1:0]    q_ff    [Q_W+1];
   logic [DEN_W-1:0]  den_ff  [Q_W+1];
   logic              sat_ff  [Q_W+1];
   logic [SIDE_W-1:0] side_ff [Q_W+1];
   logic              vld_ff  [Q_W+1];

   assign num_ext = CMP_W'(in_num);
   assign lim_ext = CMP_W'(in_den) << Q_W;

   // entry stage: overflow check and upper numerator bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
      if (en) begin
         sat_ff[0]  <= (num_ext >= lim_ext);
         rem_ff[0]  <= REM_W'(in_num >> Q_W);
         low_ff[0]  <= in_num[Q_W-1:0];
         q_ff[0]    <= '0;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 1; k <= Q_W; k++) begin : g_step
      logic [REM_W-1:0] cat;
      logic             take;

      assign cat  = {rem_ff[k-1][DEN_W-1:0], low_ff[k-1][Q_W-1]};
      assign take = (cat >= REM_W'(den_ff[k-1]));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         if (en) begin
            rem_ff[k]  <= take ? (cat - REM_W'(den_ff[k-1])) : cat;
            low_ff[k]  <= low_ff[k-1] << 1;
            q_ff[k]    <= {q_ff[k-1][Q_W-2:0], take};
            den_ff[k]  <= den_ff[k-1];
            sat_ff[k]  <= sat_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[Q_W];
   assign out_quot  = sat_ff[Q_W] ? '1 : q_ff[Q_W];
   assign out_side  = side_ff[Q_W];
endmodule

[src/ptab_back.sv]
// ----------------------------------------------------------------------------
// ptab_back
// scaled extents, box edges, rounding half away from zero, saturation
// ----------------------------------------------------------------------------
module ptab_back #(
   parameter int CW = ptab_pkg::COORD_WIDTH_DEF,
   parameter int FB = ptab_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  ptab_pkg::scale_type           in_s,
   input  logic [CW-1:0]                 in_ex,
   input  logic [CW-1:0]                 in_ey,
   input  logic signed [CW+1:0]          in_sx,
   input  logic signed [CW+1:0]          in_sy,
   input  logic                          in_deg,
   output logic                          out_valid,
   output logic signed [ptab_pkg::POS_W-1:0] out_left,
   output logic signed [ptab_pkg::POS_W-1:0] out_top,
   output logic [ptab_pkg::LEN_W-1:0]    out_width,
   output logic [ptab_pkg::LEN_W-1:0]    out_height,
   output logic                          out_deg
);
   import ptab_pkg::*;

   localparam int WQ_W    = S_BITS + CW + 1;
   localparam int G       = S_FRAC + 1 + FB;
   localparam int LSH     = S_FRAC + FB;
   localparam int LW      = CW + FB + 22;
   localparam int MW      = LW + 1;
   localparam int QMW     = MW - G;
   localparam int LXW     = WQ_W + LEN_W + 1;
   localparam int CENT_SH = S_FRAC - 1;
   localparam int POS_MAX = (1 << (POS_W - 1)) - 1;
   localparam int POS_MIN = 1 << (POS_W - 1);
   localparam int LEN_MAX = (1 << LEN_W) - 1;

   logic [WQ_W-1:0] one_q;

   // stage 1
   logic                 v1_ff, deg1_ff;
   logic [WQ_W-1:0]      wq1_ff, hq1_ff;
   logic signed [CW+1:0] sx1_ff, sy1_ff;
   // stage 2
   logic                 v2_ff, deg2_ff;
   logic signed [LW-1:0] lx2_ff, ly2_ff;
   logic [LXW-1:0]       lw2_ff, lh2_ff;
   logic signed [LW-1:0] lx_in, ly_in;
   // stage 3
   logic                 v3_ff, deg3_ff, nx3_ff, ny3_ff;
   logic [MW-1:0]        mx3_ff, my3_ff;
   logic [LXW-1:0]       lw3_ff, lh3_ff;
   logic [MW-1:0]        mx_in, my_in;
   // output register
   logic                 v4_ff, deg4_ff;
   logic signed [POS_W-1:0] left_ff, top_ff;
   logic [LEN_W-1:0]     width_ff, height_ff;
   logic [QMW-1:0]       qx, qy;
   logic [LXW-1:0]       sw, sh;
   logic signed [POS_W-1:0] left_in, top_in;
   logic [LEN_W-1:0]     width_in, height_in;

   assign one_q = WQ_W'(1) << LSH;

   // edge = 4*centroid*2^CENT_SH - one pixel - half the scaled extent
   assign lx_in = (LW'(sx1_ff) <<< CENT_SH) - (LW'(1) <<< G) - $signed(LW'(wq1_ff));
   assign ly_in = (LW'(sy1_ff) <<< CENT_SH) - (LW'(1) <<< G) - $signed(LW'(hq1_ff));

   assign mx_in = (lx2_ff[LW-1] ? MW'(-lx2_ff) : MW'(lx2_ff)) + (MW'(1) << (G - 1));
   assign my_in = (ly2_ff[LW-1] ? MW'(-ly2_ff) : MW'(ly2_ff)) + (MW'(1) << (G - 1));

   always_comb begin
      qx = QMW'(mx3_ff >> G);
      qy = QMW'(my3_ff >> G);
      sw = lw3_ff >> LSH;
      sh = lh3_ff >> LSH;
      if (!nx3_ff) begin
         left_in = (qx > QMW'(POS_MAX)) ? POS_W'(POS_MAX) : POS_W'(qx);
      end else begin
         left_in = (qx > QMW'(POS_MIN)) ? POS_W'(POS_MIN) : POS_W'(~qx + 1'b1);
      end
      if (!ny3_ff) begin
         top_in = (qy > QMW'(POS_MAX)) ? POS_W'(POS_MAX) : POS_W'(qy);
      end else begin
         top_in = (qy > QMW'(POS_MIN)) ? POS_W'(POS_MIN) : POS_W'(~qy + 1'b1);
      end
      width_in  = (sw > LXW'(LEN_MAX)) ? LEN_W'(LEN_MAX) : sw[LEN_W-1:0];
      height_in = (sh > LXW'(LEN_MAX)) ? LEN_W'(LEN_MAX) : sh[LEN_W-1:0];
      if (deg3_ff) begin
         left_in   = '0;
         top_in    = '0;
         width_in  = '0;
         height_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (en) begin
         wq1_ff    <= WQ_W'(in_s) * WQ_W'(in_ex) + one_q;
         hq1_ff    <= WQ_W'(in_s) * WQ_W'(in_ey) + one_q;
         sx1_ff    <= in_sx;
         sy1_ff    <= in_sy;
         deg1_ff   <= in_deg;

         lx2_ff    <= lx_in;
         ly2_ff    <= ly_in;
         lw2_ff    <= LXW'(wq1_ff) + (LXW'(1) << (LSH - 1));
         lh2_ff    <= LXW'(hq1_ff) + (LXW'(1) << (LSH - 1));
         deg2_ff   <= deg1_ff;

         nx3_ff    <= lx2_ff[LW-1];
         ny3_ff    <= ly2_ff[LW-1];
         mx3_ff    <= mx_in;
         my3_ff    <= my_in;
         lw3_ff    <= lw2_ff;
         lh3_ff    <= lh2_ff;
         deg3_ff   <= deg2_ff;

         left_ff   <= left_in;
         top_ff    <= top_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         deg4_ff   <= deg3_ff;
      end
   end

   assign out_valid  = v4_ff;
   assign out_left   = left_ff;
   assign out_top    = top_ff;
   assign out_width  = width_ff;
   assign out_height = height_ff;
   assign out_deg    = deg4_ff;
endmodule

[src/polygon_to_axis_aligned_box_unit.sv]
// ----------------------------------------------------------------------------
// polygon_to_axis_aligned_box_unit
// axis aligned box of equal area from the four corners of a quadrilateral
// ----------------------------------------------------------------------------
// req_ channel: eight signed corner coordinates of one quadrilateral per item.
// rsp_ channel: rounded left, top, width and height in whole pixels, plus the
//   degenerate flag, raised with all box fields zero when the extent area is 0.
// An item is taken on an edge with valid high and stall low on its channel.
// The pipeline is five front stages, one stage per root bit of d12*d23*2^64,
// 37 divider stages, 18 scale root stages and four back stages. One item
// enters per cycle when rsp_stall is low; every stage holds its contents
// while rsp_stall is high and an item waits at the output, and req_stall
// follows that condition in the same cycle. Reset clears all valid bits;
// the pipeline keeps no other state.
// ----------------------------------------------------------------------------
`include "polygon_to_axis_aligned_box_unit_assert.svh"

module polygon_to_axis_aligned_box_unit #(
   parameter int COORD_WIDTH     = ptab_pkg::COORD_WIDTH_DEF,
   parameter int COORD_FRAC_BITS = ptab_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COORD_WIDTH-1:0]     req_corner0_x,
   input  logic signed [COORD_WIDTH-1:0]     req_corner0_y,
   input  logic signed [COORD_WIDTH-1:0]     req_corner1_x,
   input  logic signed [COORD_WIDTH-1:0]     req_corner1_y,
   input  logic signed [COORD_WIDTH-1:0]     req_corner2_x,
   input  logic signed [COORD_WIDTH-1:0]     req_corner2_y,
   input  logic signed [COORD_WIDTH-1:0]     req_corner3_x,
   input  logic signed [COORD_WIDTH-1:0]     req_corner3_y,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ptab_pkg::POS_W-1:0] rsp_box_left,
   output logic signed [ptab_pkg::POS_W-1:0] rsp_box_top,
   output logic [ptab_pkg::LEN_W-1:0]        rsp_box_width,
   output logic [ptab_pkg::LEN_W-1:0]        rsp_box_height,
   output logic                              rsp_degenerate
);
   import ptab_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int DW     = 2 * CW + 1;
   localparam int RW     = DW + RAD_PAD / 2;
   localparam int SIDE1  = 4 * CW + 2 * (CW + 2) + 1;
   localparam int SIDE2  = 2 * CW + 2 * (CW + 2) + 1;

   logic                 en;

   logic                 f_valid, f_deg;
   logic [2*DW-1:0]      f_prod;
   logic [CW-1:0]        f_ex, f_ey;
   logic [2*CW-1:0]      f_a2;
   logic signed [CW+1:0] f_sx, f_sy;

   logic                 r_valid;
   logic [RW-1:0]        r_root;
   logic [SIDE1-1:0]     r_side;
   logic [2*CW-1:0]      r_a2;

   logic                 d_valid;
   quot_type             d_quot;
   logic [SIDE2-1:0]     d_side;

   logic                 s_valid;
   scale_type            s_scale;
   logic [SIDE2-1:0]     s_side;
   logic [CW-1:0]        s_ex, s_ey;
   logic signed [CW+1:0] s_sx, s_sy;
   logic                 s_deg;

   // whole pipeline moves unless a finished item is held at the output
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   ptab_front #(.CW(CW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .c0x       (req_corner0_x),
      .c0y       (req_corner0_y),
      .c1x       (req_corner1_x),
      .c1y       (req_corner1_y),
      .c2x       (req_corner2_x),
      .c2y       (req_corner2_y),
      .c3x       (req_corner3_x),
      .c3y       (req_corner3_y),
      .out_valid (f_valid),
      .out_prod  (f_prod),
      .out_ex    (f_ex),
      .out_ey    (f_ey),
      .out_a2    (f_a2),
      .out_sx    (f_sx),
      .out_sy    (f_sy),
      .out_deg   (f_deg)
   );

   // root of d12*d23 scaled by 2^64
   ptab_isqrt #(.RAD_W(2 * RW), .SIDE_W(SIDE1)) u_root_area (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_rad    ({f_prod, {RAD_PAD{1'b0}}}),
      .in_side   ({f_a2, f_ex, f_ey, f_sx, f_sy, f_deg}),
      .out_valid (r_valid),
      .out_root  (r_root),
      .out_side  (r_side)
   );

   assign r_a2 = r_side[SIDE1-1 -: 2*CW];

   ptab_div #(.NUM_W(RW), .DEN_W(2 * CW), .Q_W(Q_BITS), .SIDE_W(SIDE2)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r_valid),
      .in_num    (r_root),
      .in_den    (r_a2),
      .in_side   (r_side[SIDE2-1:0]),
      .out_valid (d_valid),
      .out_quot  (d_quot),
      .out_side  (d_side)
   );

   ptab_isqrt #(.RAD_W(Q_BITS), .SIDE_W(SIDE2)) u_root_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_rad    (d_quot),
      .in_side   (d_side),
      .out_valid (s_valid),
      .out_root  (s_scale),
      .out_side  (s_side)
   );

   assign {s_ex, s_ey, s_sx, s_sy, s_deg} = s_side;

   ptab_back #(.CW(CW), .FB(COORD_FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (s_valid),
      .in_s       (s_scale),
      .in_ex      (s_ex),
      .in_ey      (s_ey),
      .in_sx      (s_sx),
      .in_sy      (s_sy),
      .in_deg     (s_deg),
      .out_valid  (rsp_valid),
      .out_left   (rsp_box_left),
      .out_top    (rsp_box_top),
      .out_width  (rsp_box_width),
      .out_height (rsp_box_height),
      .out_deg    (rsp_degenerate)
   );

   `PTAB_ASSERT(a_deg_zero, clock, reset, rsp_valid && rsp_degenerate |-> rsp_box_left == '0 && rsp_box_top == '0 && rsp_box_width == '0 && rsp_box_height == '0)
   `PTAB_ASSERT(a_min_size, clock, reset, rsp_valid && !rsp_degenerate |-> rsp_box_width != '0 && rsp_box_height != '0)
   `PTAB_ASSERT_NR(a_reset_empty, clock, $past(reset) |-> !rsp_valid)
endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench for polygon_to_axis_aligned_box_unit
// drives quadrilaterals through the box unit with random idling on both sides
// and checks every box against a bit-exact fixed-point predictor or a table entry
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import ptab_pkg::*;

   localparam int CW          = 16;
   localparam int NUM_RANDOM  = 550;
   localparam int NUM_DIRECT  = 12;
   localparam int DRAIN       = 300;
   localparam int CYCLE_LIMIT = 400000;

   typedef logic [7:0][CW-1:0] corners_t;

   typedef struct packed {
      logic signed [POS_W-1:0] left_px;
      logic signed [POS_W-1:0] top_px;
      logic [LEN_W-1:0]        width_px;
      logic [LEN_W-1:0]        height_px;
      logic                    degen;
   } box_t;

   typedef struct {
      bit   typed;
      box_t box;
   } typed_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   corners_t req_c = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [POS_W-1:0] rsp_box_left;
   logic signed [POS_W-1:0] rsp_box_top;
   logic [LEN_W-1:0] rsp_box_width;
   logic [LEN_W-1:0] rsp_box_height;
   logic rsp_degenerate;

   box_t   box_q[$];
   typed_t typed_q[$];
   int     error_count = 0;
   int     cycle_count = 0;
   int     boxes_seen = 0;

   // x0 y0 x1 y1 x2 y2 x3 y3, typed flag, left top width height degenerate
   int directed [0:NUM_DIRECT-1][0:13] = '{
      '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1},
      '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1, 0, 0, 0, 0, 1},
      '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
        1, 0, 0, 0, 0, 1},
      '{-32768, 5, 32767, 5, 0, 5, 100, 5, 1, 0, 0, 0, 0, 1},
      '{-7, -32768, -7, 32767, -7, 0, -7, 9, 1, 0, 0, 0, 0, 1},
      // all but the first corner coincide: zero area product, one pixel box
      '{0, 0, 160, 160, 160, 160, 160, 160, 1, 6, 6, 1, 1, 0},
      '{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
        0, 0, 0, 0, 0, 0},
      '{0, 0, 16, 0, 16, 16, 0, 16, 0, 0, 0, 0, 0, 0},
      '{0, 160, 160, 0, 0, -160, -160, 0, 0, 0, 0, 0, 0, 0},
      // thin box with long sides: scale saturates
      '{-32768, 0, -32768, 0, 32767, 1, -32768, 0, 0, 0, 0, 0, 0, 0},
      '{32767, 32767, 32767, 32766, -32768, 32767, 32767, 32767,
        0, 0, 0, 0, 0, 0},
      '{24, 8, -40, 56, -8, -72, 56, -24, 0, 0, 0, 0, 0, 0}
   };

   polygon_to_axis_aligned_box_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_corner0_x  (req_c[0]),
      .req_corner0_y  (req_c[1]),
      .req_corner1_x  (req_c[2]),
      .req_corner1_y  (req_c[3]),
      .req_corner2_x  (req_c[4]),
      .req_corner2_y  (req_c[5]),
      .req_corner3_x  (req_c[6]),
      .req_corner3_y  (req_c[7]),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_box_left   (rsp_box_left),
      .rsp_box_top    (rsp_box_top),
      .rsp_box_width  (rsp_box_width),
      .rsp_box_height (rsp_box_height),
      .rsp_degenerate (rsp_degenerate)
   );

   always #2 clock = ~clock;

   function automatic longint round_half_sat(longint v, int sh, longint lo, longint hi);
      longint half;
      longint q;
      half = longint'(1) <<< (sh - 1);
      if (v >= 0) begin
         q = (v + half) >>> sh;
      end else begin
         q = -((-v + half) >>> sh);
      end
      if (q < lo) q = lo;
      if (q > hi) q = hi;
      return q;
   endfunction

   function automatic box_t predict_box(corners_t c);
      longint xs[4];
      longint ys[4];
      longint xmin, xmax, ymin, ymax, ex, ey, a2, d12, d23, sx, sy, wq, hq;
      logic [255:0] rhs, a2sq, t;
      logic [S_BITS-1:0] s, trial;
      box_t r;
      for (int i = 0; i < 4; i++) begin
         xs[i] = longint'($signed(c[2*i]));
         ys[i] = longint'($signed(c[2*i+1]));
      end
      xmin = xs[0]; xmax = xs[0]; ymin = ys[0]; ymax = ys[0];
      sx = 0; sy = 0;
      for (int i = 0; i < 4; i++) begin
         if (xs[i] < xmin) xmin = xs[i];
         if (xs[i] > xmax) xmax = xs[i];
         if (ys[i] < ymin) ymin = ys[i];
         if (ys[i] > ymax) ymax = ys[i];
         sx += xs[i];
         sy += ys[i];
      end
      ex = xmax - xmin;
      ey = ymax - ymin;
      a2 = ex * ey;
      r = '0;
      if (a2 == 0) begin
         r.degen = 1'b1;
         return r;
      end
      d12 = (xs[1]-xs[2])*(xs[1]-xs[2]) + (ys[1]-ys[2])*(ys[1]-ys[2]);
      d23 = (xs[2]-xs[3])*(xs[2]-xs[3]) + (ys[2]-ys[3])*(ys[2]-ys[3]);
      rhs = (256'(d12) * 256'(d23)) << 64;
      a2sq = 256'(a2) * 256'(a2);
      // largest s with s^4 * a2^2 <= d12 * d23 * 2^64
      s = '0;
      for (int b = S_BITS - 1; b >= 0; b--) begin
         trial = s | (18'd1 << b);
         t = 256'(trial) * 256'(trial);
         t = t * t * a2sq;
         if (t <= rhs) s = trial;
      end
      wq = longint'(s) * ex + (longint'(1) <<< 20);
      hq = longint'(s) * ey + (longint'(1) <<< 20);
      r.left_px   = POS_W'(round_half_sat(sx * 32768 - (longint'(1) <<< 21) - wq,
                                          21, -8192, 8191));
      r.top_px    = POS_W'(round_half_sat(sy * 32768 - (longint'(1) <<< 21) - hq,
                                          21, -8192, 8191));
      r.width_px  = LEN_W'(round_half_sat(wq, 20, 0, 8191));
      r.height_px = LEN_W'(round_half_sat(hq, 20, 0, 8191));
      return r;
   endfunction

   function automatic corners_t random_polygon();
      int kind, ccx, ccy, a, b, m, ux, uy, vx, vy;
      corners_t c;
      kind = $urandom_range(0, 9);
      ccx = $urandom_range(0, 4000) - 2000;
      ccy = $urandom_range(0, 4000) - 2000;
      if (kind < 6) begin
         // rotated rectangle, sides (a,b) and a perpendicular scaled by m/2
         a = $urandom_range(0, 6000) - 3000;
         b = $urandom_range(0, 6000) - 3000;
         m = $urandom_range(1, 3);
         ux = a; uy = b;
         vx = -(b * m) / 2; vy = (a * m) / 2;
         c[0] = CW'(ccx + ux + vx); c[1] = CW'(ccy + uy + vy);
         c[2] = CW'(ccx - ux + vx); c[3] = CW'(ccy - uy + vy);
         c[4] = CW'(ccx - ux - vx); c[5] = CW'(ccy - uy - vy);
         c[6] = CW'(ccx + ux - vx); c[7] = CW'(ccy + uy - vy);
      end else if (kind == 6) begin
         a = $urandom_range(1, 8000);
         b = $urandom_range(1, 8000);
         c[0] = CW'(ccx);     c[1] = CW'(ccy);
         c[2] = CW'(ccx + a); c[3] = CW'(ccy);
         c[4] = CW'(ccx + a); c[5] = CW'(ccy + b);
         c[6] = CW'(ccx);     c[7] = CW'(ccy + b);
      end else if (kind < 9) begin
         for (int i = 0; i < 8; i++) c[i] = CW'($urandom);
      end else begin
         // collinear on one axis: zero extent area
         for (int i = 0; i < 8; i++) c[i] = CW'($urandom);
         a = $urandom_range(0, 1);
         for (int i = 0; i < 4; i++) c[2*i+a] = c[a];
      end
      return c;
   endfunction

   function automatic int random_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report(string field, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      error_count++;
   endtask

   task automatic send_polygon(corners_t c, bit typed, box_t box);
      int gap;
      typed_t tv;
      gap = random_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      tv.typed = typed;
      tv.box   = box;
      typed_q = {typed_q, tv};
      req_c     <= c;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // expected box for each accepted item
   always @(posedge clock) begin
      typed_t tv;
      box_t   want_box;
      if (!reset && req_valid && !req_stall) begin
         tv = typed_q.pop_front();
         want_box = tv.typed ? tv.box : predict_box(req_c);
         box_q = {box_q, want_box};
      end
   end

   always @(posedge clock) begin
      box_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         boxes_seen++;
         if (box_q.size() == 0) begin
            report("unexpected box", 1, 0);
         end else begin
            want = box_q.pop_front();
            if (rsp_box_left !== want.left_px) report("left", rsp_box_left, want.left_px);
            if (rsp_box_top !== want.top_px) report("top", rsp_box_top, want.top_px);
            if (rsp_box_width !== want.width_px)
               report("width", rsp_box_width, want.width_px);
            if (rsp_box_height !== want.height_px)
               report("height", rsp_box_height, want.height_px);
            if (rsp_degenerate !== want.degen)
               report("degenerate", rsp_degenerate, want.degen);
         end
      end
   end

   // receiver idling, with one long hold-off so the pipe fills
   initial begin
      int n;
      bit held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && boxes_seen >= 150) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat (50) @(posedge clock);
         end else if ((boxes_seen / 100) % 2 == 1) begin
            // stretch with no stall
            rsp_stall <= 1'b0;
         end else begin
            n = random_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin
      corners_t c;
      box_t box;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int r = 0; r < NUM_DIRECT; r++) begin
         for (int i = 0; i < 8; i++) c[i] = CW'(directed[r][i]);
         box.left_px   = POS_W'(directed[r][9]);
         box.top_px    = POS_W'(directed[r][10]);
         box.width_px  = LEN_W'(directed[r][11]);
         box.height_px = LEN_W'(directed[r][12]);
         box.degen     = directed[r][13][0];
         send_polygon(c, directed[r][8] != 0, box);
      end
      for (int k = 0; k < NUM_RANDOM; k++) begin
         send_polygon(random_polygon(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (box_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (box_q.size() != 0 || typed_q.size() != 0) begin
         report("items left without a box", box_q.size() + typed_q.size(), 0);
      end
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
